### rtl/core/rdi_pkg.sv
// Package for the read-discrete-inputs response block: sizes, codes and payload types.
// No dependencies; every module of the block imports it.

package rdi_pkg;

   // Status table geometry.
   localparam int TABLE_WORDS = 64;
   localparam int WORD_W      = 16;
   localparam int TBL_AW      = $clog2(TABLE_WORDS);
   localparam int TBL_BW      = $clog2(TABLE_WORDS * WORD_W);

   // Request limits and frame geometry.
   localparam int MAX_BITS  = 256;
   localparam int QTY_W     = $clog2(MAX_BITS + 1);
   localparam int MAX_BYTES = (MAX_BITS + 7) / 8;
   localparam int NB_W      = $clog2(MAX_BYTES + 1);
   localparam int HDR_LEN   = 9;
   localparam int FRAME_MAX = HDR_LEN + MAX_BYTES;
   localparam int POS_W     = $clog2(FRAME_MAX);

   // Word window in front of the data packer.
   localparam int WIN_DEPTH = 3;

   // Command codes.
   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_READ  = 1'b1;

   typedef struct packed {
      logic        command;
      logic [5:0]  word_index;
      logic [15:0] word_value;
      logic [15:0] transaction_id;
      logic [15:0] protocol_id;
      logic [7:0]  unit_id;
      logic [7:0]  function_code;
      logic [15:0] start_address;
      logic [15:0] bit_quantity;
   } req_type;

   typedef struct packed {
      logic [7:0] frame_byte;
      logic       last_byte;
      logic [5:0] frame_length;
   } rsp_type;

   typedef struct packed {
      logic              en;
      logic [TBL_AW-1:0] addr;
      logic [WORD_W-1:0] data;
   } tbl_wr_type;

   typedef struct packed {
      logic              en;
      logic [TBL_AW-1:0] addr;
   } tbl_rd_type;

endpackage

### rtl/core/rdi_table.sv
// Status word table: one-port write, one-port read with registered data.
// Per-word valid flags give the cleared-at-reset view. Depends on rdi_pkg.

module rdi_table (
   input  logic                        clock,
   input  logic                        reset,
   input  rdi_pkg::tbl_wr_type         wr,
   input  rdi_pkg::tbl_rd_type         rd,
   output logic [rdi_pkg::WORD_W-1:0]  rd_word
);
   import rdi_pkg::*;

   logic [WORD_W-1:0]      mem [TABLE_WORDS];
   logic [TABLE_WORDS-1:0] vld_ff, vld_in;
   logic [WORD_W-1:0]      rd_q_ff;
   logic                   rd_vld_ff, rd_vld_in;

   always_comb begin
      vld_in = vld_ff;
      if (wr.en) begin
         vld_in[wr.addr] = 1'b1;
      end
      rd_vld_in = rd_vld_ff;
      if (rd.en) begin
         rd_vld_in = vld_ff[rd.addr];
      end
   end

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      if (rd.en) begin
         rd_q_ff <= mem[rd.addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         vld_ff    <= vld_in;
         rd_vld_ff <= rd_vld_in;
      end
   end

   // never-written words read as zero
   assign rd_word = rd_vld_ff ? rd_q_ff : '0;

endmodule

### rtl/core/rdi_framer.sv
// Response sequencer: header bytes, word window fed from the table, bit packer,
// and the output register. Depends on rdi_pkg.

module rdi_framer (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  rdi_pkg::req_type            req,
   output logic                        busy,
   output rdi_pkg::tbl_rd_type         rd,
   input  logic [rdi_pkg::WORD_W-1:0]  rd_word,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output rdi_pkg::rsp_type            rsp_data
);
   import rdi_pkg::*;

   // header byte positions
   localparam logic [POS_W-1:0] P_TID_HI = POS_W'(0);
   localparam logic [POS_W-1:0] P_TID_LO = POS_W'(1);
   localparam logic [POS_W-1:0] P_PID_HI = POS_W'(2);
   localparam logic [POS_W-1:0] P_PID_LO = POS_W'(3);
   localparam logic [POS_W-1:0] P_LEN_HI = POS_W'(4);
   localparam logic [POS_W-1:0] P_LEN_LO = POS_W'(5);
   localparam logic [POS_W-1:0] P_UNIT   = POS_W'(6);
   localparam logic [POS_W-1:0] P_FUNC   = POS_W'(7);
   localparam logic [POS_W-1:0] P_COUNT  = POS_W'(8);

   logic                  active_ff, active_in;
   logic [POS_W-1:0]      pos_ff, pos_in;
   logic [POS_W-1:0]      flast_ff, flast_in;
   logic [NB_W-1:0]       nbytes_ff, nbytes_in;
   logic [QTY_W-1:0]      rem_ff, rem_in;
   logic [3:0]            off_ff, off_in;
   logic [TBL_AW-1:0]     rptr_ff, rptr_in;
   logic                  inflight_ff, inflight_in;
   logic [1:0]            cnt_ff, cnt_in;
   logic [WIN_DEPTH-1:0][WORD_W-1:0] win_ff, win_in;
   logic [15:0]           tid_ff, tid_in, pid_ff, pid_in;
   logic [7:0]            uid_ff, uid_in, fc_ff, fc_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_data_ff, rsp_data_in;

   // request decode
   logic [QTY_W-1:0]      qty_sat;
   logic [QTY_W:0]        nb_full;
   logic [TBL_BW-1:0]     base;

   // datapath
   logic                  out_free, is_hdr, emit, pop, push, last;
   logic [2:0]            occ;
   logic                  rd_en;
   logic [1:0]            cnt_mid;
   logic [2*WORD_W-1:0]   win_bits;
   logic [7:0]            data_mask, data_byte, hdr_byte, len_byte;
   logic [7:0]            flen8;
   logic                  rem_ge8;

   always_comb begin
      if (req.bit_quantity > 16'(MAX_BITS)) begin
         qty_sat = QTY_W'(MAX_BITS);
      end else begin
         qty_sat = QTY_W'(req.bit_quantity);
      end
      nb_full = ({1'b0, qty_sat} + (QTY_W + 1)'(7)) >> 3;
      // one-based to zero-based, wrapped to the table size in bits
      base    = TBL_BW'(req.start_address - 16'd1);
   end

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign is_hdr   = pos_ff < POS_W'(HDR_LEN);
   assign emit     = active_ff && out_free && (is_hdr || cnt_ff >= 2'd2);
   assign pop      = emit && !is_hdr && off_ff[3];
   assign push     = inflight_ff;
   assign last     = pos_ff == flast_ff;
   assign occ      = {1'b0, cnt_ff} + {2'b00, inflight_ff};
   assign rd_en    = active_ff && (occ < 3'(WIN_DEPTH));

   assign rd.en   = rd_en;
   assign rd.addr = rptr_ff;

   // byte packer: eight bits from the two oldest window words
   assign win_bits  = {win_ff[1], win_ff[0]} >> off_ff;
   assign rem_ge8   = rem_ff >= QTY_W'(8);
   assign data_mask = rem_ge8 ? 8'hFF : ~(8'hFF << rem_ff[2:0]);
   assign data_byte = win_bits[7:0] & data_mask;

   assign len_byte = 8'(3) + 8'(nbytes_ff);
   assign flen8    = 8'(HDR_LEN) + 8'(nbytes_ff);

   always_comb begin
      case (pos_ff)
         P_TID_HI: hdr_byte = tid_ff[15:8];
         P_TID_LO: hdr_byte = tid_ff[7:0];
         P_PID_HI: hdr_byte = pid_ff[15:8];
         P_PID_LO: hdr_byte = pid_ff[7:0];
         P_LEN_HI: hdr_byte = 8'h00;
         P_LEN_LO: hdr_byte = len_byte;
         P_UNIT:   hdr_byte = uid_ff;
         P_FUNC:   hdr_byte = fc_ff;
         P_COUNT:  hdr_byte = 8'(nbytes_ff);
         default:  hdr_byte = data_byte;
      endcase
   end

   always_comb begin
      active_in   = active_ff;
      pos_in      = pos_ff;
      flast_in    = flast_ff;
      nbytes_in   = nbytes_ff;
      rem_in      = rem_ff;
      off_in      = off_ff;
      rptr_in     = rptr_ff;
      inflight_in = inflight_ff;
      cnt_in      = cnt_ff;
      win_in      = win_ff;
      tid_in      = tid_ff;
      pid_in      = pid_ff;
      uid_in      = uid_ff;
      fc_in       = fc_ff;
      cnt_mid     = cnt_ff - {1'b0, pop};

      if (start) begin
         active_in   = 1'b1;
         pos_in      = '0;
         nbytes_in   = NB_W'(nb_full);
         flast_in    = POS_W'(HDR_LEN - 1) + POS_W'(nb_full);
         rem_in      = qty_sat;
         off_in      = base[3:0];
         rptr_in     = base[TBL_BW-1:4];
         inflight_in = 1'b0;   // drop any fetch left from the last frame
         cnt_in      = '0;
         tid_in      = req.transaction_id;
         pid_in      = req.protocol_id;
         uid_in      = req.unit_id;
         fc_in       = req.function_code;
      end else begin
         inflight_in = rd_en;
         if (rd_en) begin
            if (rptr_ff == TBL_AW'(TABLE_WORDS - 1)) begin
               rptr_in = '0;
            end else begin
               rptr_in = rptr_ff + TBL_AW'(1);
            end
         end

         // window: shift on a word crossing, append returning read data
         if (pop) begin
            win_in[0] = win_ff[1];
            win_in[1] = win_ff[2];
         end
         if (push) begin
            case (cnt_mid)
               2'd0:    win_in[0] = rd_word;
               2'd1:    win_in[1] = rd_word;
               default: win_in[2] = rd_word;
            endcase
         end
         cnt_in = cnt_mid + {1'b0, push};

         if (emit) begin
            pos_in = pos_ff + POS_W'(1);
            if (last) begin
               active_in = 1'b0;
            end
            if (!is_hdr) begin
               off_in = off_ff + 4'd8;
               rem_in = rem_ge8 ? rem_ff - QTY_W'(8) : '0;
            end
         end
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (out_free) begin
         rsp_valid_in = emit;
         if (emit) begin
            rsp_data_in.frame_byte   = hdr_byte;
            rsp_data_in.last_byte    = last;
            rsp_data_in.frame_length = flen8[5:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         inflight_ff  <= 1'b0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         inflight_ff  <= inflight_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff      <= pos_in;
      flast_ff    <= flast_in;
      nbytes_ff   <= nbytes_in;
      rem_ff      <= rem_in;
      off_ff      <= off_in;
      rptr_ff     <= rptr_in;
      win_ff      <= win_in;
      tid_ff      <= tid_in;
      pid_ff      <= pid_in;
      uid_ff      <= uid_in;
      fc_ff       <= fc_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign busy      = active_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

### rtl/core/read_discrete_inputs_response.sv
// Top level of the read-discrete-inputs response builder.
// Depends on rdi_pkg, rdi_table and rdi_framer.
//
// Usage:
//  - req channel (req_valid / req_stall / req_data): one command per transfer.
//    A write command stores word_value at word_index of the 64-word status
//    table and produces nothing.
//  - A read command produces the response frame on the rsp channel, one
//    byte per transfer: nine header bytes, then ceil(quantity/8) data bytes
//    (quantity saturated to 256), bits packed LSB first. Every byte carries
//    last_byte and the total frame_length.
//  - The first header byte is registered into the output register once the
//    read transfer has set the sequencer active. With no stall, one byte
//    follows per cycle. The frame sequencer is the limit: req_stall stays
//    high while a frame is being built.
//  - Data bytes come from a three-word window refilled through the table's
//    single read port (registered read); a word is fetched every
//    second data byte, which keeps pace with the output.
//  - rsp_stall holds the output register; the sequencer waits behind it.
//    The next command is taken while the last byte still waits.
//  - Reset clears the table (per-word valid flags) and the framer's busy state.

module read_discrete_inputs_response (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  rdi_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rdi_pkg::rsp_type  rsp_data
);
   import rdi_pkg::*;

   logic        req_xfer;
   logic        start;
   logic        busy;
   tbl_wr_type  tbl_wr;
   tbl_rd_type  tbl_rd;
   logic [WORD_W-1:0] tbl_word;

   // commands are taken only while no frame is in progress,
   // so table writes never overlap frame reads
   assign req_stall = busy;
   assign req_xfer  = req_valid && !req_stall;
   assign start     = req_xfer && (req_data.command == CMD_READ);

   // out-of-range word indexes are dropped
   assign tbl_wr.en   = req_xfer && (req_data.command == CMD_WRITE) &&
                        (32'(req_data.word_index) < TABLE_WORDS);
   assign tbl_wr.addr = TBL_AW'(req_data.word_index);
   assign tbl_wr.data = req_data.word_value;

   rdi_table u_table (
      .clock   (clock),
      .reset   (reset),
      .wr      (tbl_wr),
      .rd      (tbl_rd),
      .rd_word (tbl_word)
   );

   rdi_framer u_framer (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req       (req_data),
      .busy      (busy),
      .rd        (tbl_rd),
      .rd_word   (tbl_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // a read transfer closes the request side until the frame is built
   a_read_locks: assert property (@(posedge clock) disable iff (reset)
      start |=> req_stall)
      else $error("request side open after read transfer");

   // a write never starts a frame
   a_write_quiet: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && req_data.command == CMD_WRITE && !busy) |=> !req_stall)
      else $error("write command started a frame");

   // all bytes of one frame carry the same length
   a_len_steady: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !rsp_data.last_byte) |=>
         (!rsp_valid || rsp_data.frame_length == $past(rsp_data.frame_length)))
      else $error("frame length changed inside a frame");

   // frame length never below the header size
   a_len_floor: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.frame_length >= 6'(HDR_LEN))
      else $error("frame length below header size");

endmodule
